// ===== hdl/btpt_pkg.sv =====
`default_nettype none
package btpt_pkg;

    localparam int NODES        = 1024;
    localparam int NODE_AW      = $clog2(NODES);
    localparam int COUNT_W      = $clog2(NODES + 1);
    localparam int VALUE_BITS   = 16;
    localparam int MAX_KEY_BITS = 32;
    localparam int KEY_LEN_W    = 6;
    localparam int PATH_DEPTH   = MAX_KEY_BITS + 1;
    localparam int PATH_AW      = $clog2(PATH_DEPTH);

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(MAX_KEY_BITS);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_EXACT  = 2'd2,
        OP_LPM    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_code_t;

    typedef struct packed {
        logic [NODE_AW-1:0]    child_zero;
        logic [NODE_AW-1:0]    child_one;
        logic [1:0]            flags;
        logic [VALUE_BITS-1:0] value;
        logic                  valid;
    } node_rec_t;

    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_START,
        CMD_WAIT,
        CMD_WALK_CHK,
        CMD_DISPATCH,
        CMD_ALLOC_NEW,
        CMD_ALLOC_LINK,
        CMD_ADD_SET,
        CMD_PRUNE_WR,
        CMD_PATH_LOAD,
        CMD_PRUNE_MOD,
        CMD_RESP
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_WALK_RD,
        S_WALK_CHK,
        S_DISPATCH,
        S_ALLOC_RD,
        S_ALLOC_NEW,
        S_ALLOC_LINK,
        S_ADD_SET,
        S_PRUNE_WR,
        S_PRUNE_PRD,
        S_PRUNE_PCUR,
        S_PRUNE_NRD,
        S_PRUNE_MOD,
        S_RESP
    } state_t;

    typedef struct packed {
        op_t  op;
        logic root_present;
        logic walk_more;
        logic need_ok;
        logic exact_hit;
        logic n_le_len;
        logic n_lt_len;
        logic n_zero;
        logic len_zero;
        logic prune_stop;
        logic i_zero;
        logic out_free;
    } dp_status_t;

    function automatic logic key_bit(input logic [MAX_KEY_BITS-1:0] key,
                                     input logic [KEY_LEN_W-1:0] kl,
                                     input logic [KEY_LEN_W-1:0] level);
        logic [KEY_LEN_W-1:0] idx;
        idx = KEY_LEN_W'(kl - KEY_LEN_W'(1) - level);
        return key[idx[$clog2(MAX_KEY_BITS)-1:0]];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/btpt_ctrl.sv =====
`default_nettype none
module btpt_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire btpt_pkg::dp_status_t  dp_status,
    output btpt_pkg::cmd_t             cmd
);
    import btpt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_IDLE;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd        = CMD_LOAD;
                    state_next = S_START;
                end
            end
            S_START: begin
                cmd        = CMD_START;
                state_next = dp_status.root_present ? S_WALK_RD : S_DISPATCH;
            end
            S_WALK_RD: begin
                cmd        = CMD_WAIT;
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                cmd        = CMD_WALK_CHK;
                state_next = dp_status.walk_more ? S_WALK_RD : S_DISPATCH;
            end
            S_DISPATCH: begin
                cmd        = CMD_DISPATCH;
                state_next = S_RESP;
                unique case (dp_status.op)
                    OP_ADD: begin
                        if (dp_status.need_ok) begin
                            state_next = dp_status.n_le_len ? S_ALLOC_RD : S_ADD_SET;
                        end
                    end
                    OP_REMOVE: begin
                        if (dp_status.exact_hit) begin
                            state_next = S_PRUNE_WR;
                        end
                    end
                    OP_EXACT, OP_LPM: begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_ALLOC_RD: begin
                cmd        = CMD_WAIT;
                state_next = S_ALLOC_NEW;
            end
            S_ALLOC_NEW: begin
                cmd = CMD_ALLOC_NEW;
                if (!dp_status.n_zero) begin
                    state_next = S_ALLOC_LINK;
                end else begin
                    state_next = dp_status.len_zero ? S_ADD_SET : S_ALLOC_RD;
                end
            end
            S_ALLOC_LINK: begin
                cmd        = CMD_ALLOC_LINK;
                state_next = dp_status.n_lt_len ? S_ALLOC_RD : S_ADD_SET;
            end
            S_ADD_SET: begin
                cmd        = CMD_ADD_SET;
                state_next = S_RESP;
            end
            S_PRUNE_WR: begin
                cmd = CMD_PRUNE_WR;
                if (dp_status.prune_stop || dp_status.i_zero) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_PRUNE_PRD;
                end
            end
            S_PRUNE_PRD: begin
                cmd        = CMD_WAIT;
                state_next = S_PRUNE_PCUR;
            end
            S_PRUNE_PCUR: begin
                cmd        = CMD_PATH_LOAD;
                state_next = S_PRUNE_NRD;
            end
            S_PRUNE_NRD: begin
                cmd        = CMD_WAIT;
                state_next = S_PRUNE_MOD;
            end
            S_PRUNE_MOD: begin
                cmd        = CMD_PRUNE_MOD;
                state_next = S_PRUNE_WR;
            end
            S_RESP: begin
                cmd = CMD_RESP;
                if (dp_status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/btpt_dp.sv =====
`default_nettype none
module btpt_dp (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire btpt_pkg::cmd_t                            cmd,
    output btpt_pkg::dp_status_t                           dp_status,
    input  wire logic                                      cfg_wr_en,
    input  wire logic [btpt_pkg::KEY_LEN_W-1:0]            cfg_wr_data,
    input  wire logic [1:0]                                s_op,
    input  wire logic [btpt_pkg::MAX_KEY_BITS-1:0]         s_key,
    input  wire logic [btpt_pkg::KEY_LEN_W-1:0]            s_prefix_len,
    input  wire logic [btpt_pkg::VALUE_BITS-1:0]           s_value,
    output logic                                           m_valid,
    input  wire logic                                      m_ready,
    output logic                                           m_found,
    output logic [btpt_pkg::VALUE_BITS-1:0]                m_result_value,
    output logic [1:0]                                     m_status
);
    import btpt_pkg::*;

    node_rec_t          node_mem [0:NODES-1];
    logic [NODE_AW-1:0] free_mem [0:NODES-1];
    logic [NODE_AW-1:0] path_mem [0:PATH_DEPTH-1];

    logic [KEY_LEN_W-1:0]    key_length_reg;
    op_t                     op_reg, op_next;
    logic [MAX_KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_LEN_W-1:0]    kl_reg, kl_next;
    logic [KEY_LEN_W-1:0]    len_reg, len_next;
    logic [VALUE_BITS-1:0]   val_reg, val_next;
    logic [KEY_LEN_W-1:0]    n_reg, n_next;
    logic [KEY_LEN_W-1:0]    i_reg, i_next;
    logic [NODE_AW-1:0]      cur_reg, cur_next;
    logic [NODE_AW-1:0]      new_reg, new_next;
    node_rec_t               nd_reg, nd_next;
    logic [NODE_AW-1:0]      root_reg, root_next;
    logic                    root_present_reg, root_present_next;
    logic [COUNT_W-1:0]      free_count_reg, free_count_next;
    logic [COUNT_W-1:0]      low_mark_reg, low_mark_next;
    logic                    res_found_reg, res_found_next;
    logic [VALUE_BITS-1:0]   res_value_reg, res_value_next;
    status_code_t            res_status_reg, res_status_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    m_found_reg, m_found_next;
    logic [VALUE_BITS-1:0]   m_value_reg, m_value_next;
    status_code_t            m_status_reg, m_status_next;

    node_rec_t          node_dout_reg;
    logic [NODE_AW-1:0] free_dout_reg;
    logic [NODE_AW-1:0] free_init_reg;
    logic               free_use_init_reg;
    logic [NODE_AW-1:0] path_dout_reg;

    logic               node_we;
    logic [NODE_AW-1:0] node_waddr;
    node_rec_t          node_wdata;
    logic               free_we;
    logic               path_we;
    logic [PATH_AW-1:0] path_waddr;
    logic [NODE_AW-1:0] path_wdata;

    logic [COUNT_W-1:0]   free_top;
    logic [NODE_AW-1:0]   free_pick;
    logic [KEY_LEN_W-1:0] kl_eff;
    logic [KEY_LEN_W-1:0] len_sat;
    logic [KEY_LEN_W:0]   need;
    logic                 walk_bit;
    logic                 link_bit;
    logic                 prune_bit;
    logic                 walk_child_ok;
    logic [NODE_AW-1:0]   walk_child;
    logic                 out_free;
    node_rec_t            zero_rec;

    assign zero_rec  = '0;
    assign free_top  = COUNT_W'(free_count_reg - COUNT_W'(1));
    assign free_pick = free_use_init_reg ? free_init_reg : free_dout_reg;
    assign out_free  = !m_valid_reg || m_ready;

    assign walk_bit  = key_bit(key_reg, kl_reg, KEY_LEN_W'(n_reg - KEY_LEN_W'(1)));
    assign link_bit  = walk_bit;
    assign prune_bit = key_bit(key_reg, kl_reg, KEY_LEN_W'(i_reg - KEY_LEN_W'(1)));

    assign walk_child_ok = node_dout_reg.flags[walk_bit];
    assign walk_child    = walk_bit ? node_dout_reg.child_one : node_dout_reg.child_zero;
    assign need          = (KEY_LEN_W+1)'(len_reg) + (KEY_LEN_W+1)'(1)
                           - (KEY_LEN_W+1)'(n_reg);

    always_comb begin
        if (key_length_reg == '0) begin
            kl_eff = KEY_LEN_W'(1);
        end else if (key_length_reg > KEY_LEN_W'(MAX_KEY_BITS)) begin
            kl_eff = KEY_LEN_W'(MAX_KEY_BITS);
        end else begin
            kl_eff = key_length_reg;
        end
        len_sat = (s_prefix_len > kl_eff) ? kl_eff : s_prefix_len;
    end

    always_comb begin
        dp_status.op           = op_reg;
        dp_status.root_present = root_present_reg;
        dp_status.walk_more    = (n_reg <= len_reg) && walk_child_ok;
        dp_status.need_ok      = COUNT_W'(need) <= free_count_reg;
        dp_status.exact_hit    = (KEY_LEN_W'(n_reg) == KEY_LEN_W'(len_reg + KEY_LEN_W'(1)))
                                 && nd_reg.valid;
        dp_status.n_le_len     = n_reg <= len_reg;
        dp_status.n_lt_len     = n_reg < len_reg;
        dp_status.n_zero       = n_reg == '0;
        dp_status.len_zero     = len_reg == '0;
        dp_status.prune_stop   = (nd_reg.flags != 2'b00) || nd_reg.valid;
        dp_status.i_zero       = i_reg == '0;
        dp_status.out_free     = out_free;
    end

    always_comb begin
        op_next           = op_reg;
        key_next          = key_reg;
        kl_next           = kl_reg;
        len_next          = len_reg;
        val_next          = val_reg;
        n_next            = n_reg;
        i_next            = i_reg;
        cur_next          = cur_reg;
        new_next          = new_reg;
        nd_next           = nd_reg;
        root_next         = root_reg;
        root_present_next = root_present_reg;
        free_count_next   = free_count_reg;
        low_mark_next     = low_mark_reg;
        res_found_next    = res_found_reg;
        res_value_next    = res_value_reg;
        res_status_next   = res_status_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_found_next      = m_found_reg;
        m_value_next      = m_value_reg;
        m_status_next     = m_status_reg;
        node_we           = 1'b0;
        node_waddr        = cur_reg;
        node_wdata        = nd_reg;
        free_we           = 1'b0;
        path_we           = 1'b0;
        path_waddr        = PATH_AW'(n_reg);
        path_wdata        = cur_reg;

        unique case (cmd)
            CMD_IDLE, CMD_WAIT: begin
            end
            CMD_LOAD: begin
                op_next         = op_t'(s_op);
                key_next        = s_key;
                kl_next         = kl_eff;
                len_next        = len_sat;
                val_next        = s_value;
                res_found_next  = 1'b0;
                res_value_next  = '0;
                res_status_next = ST_OK;
            end
            CMD_START: begin
                if (root_present_reg) begin
                    cur_next   = root_reg;
                    path_we    = 1'b1;
                    path_waddr = '0;
                    path_wdata = root_reg;
                    n_next     = KEY_LEN_W'(1);
                end else begin
                    n_next = '0;
                end
            end
            CMD_WALK_CHK: begin
                nd_next = node_dout_reg;
                if (op_reg == OP_LPM && node_dout_reg.valid) begin
                    res_found_next = 1'b1;
                    res_value_next = node_dout_reg.value;
                end
                if (n_reg <= len_reg && walk_child_ok) begin
                    cur_next   = walk_child;
                    path_we    = 1'b1;
                    path_waddr = PATH_AW'(n_reg);
                    path_wdata = walk_child;
                    n_next     = KEY_LEN_W'(n_reg + KEY_LEN_W'(1));
                end
            end
            CMD_DISPATCH: begin
                unique case (op_reg)
                    OP_ADD: begin
                        if (!dp_status.need_ok) begin
                            res_status_next = ST_FULL;
                        end
                    end
                    OP_REMOVE: begin
                        if (dp_status.exact_hit) begin
                            res_found_next = 1'b1;
                            res_value_next = nd_reg.value;
                            nd_next.valid  = 1'b0;
                            nd_next.value  = '0;
                            i_next         = len_reg;
                        end else begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_EXACT: begin
                        if (dp_status.exact_hit) begin
                            res_found_next = 1'b1;
                            res_value_next = nd_reg.value;
                        end else begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_LPM: begin
                        if (!res_found_reg) begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                endcase
            end
            CMD_ALLOC_NEW: begin
                free_count_next = free_top;
                if (free_top < low_mark_reg) begin
                    low_mark_next = free_top;
                end
                node_we    = 1'b1;
                node_waddr = free_pick;
                node_wdata = zero_rec;
                new_next   = free_pick;
                if (n_reg == '0) begin
                    root_next         = free_pick;
                    root_present_next = 1'b1;
                    path_we           = 1'b1;
                    path_waddr        = '0;
                    path_wdata        = free_pick;
                    cur_next          = free_pick;
                    nd_next           = zero_rec;
                    n_next            = KEY_LEN_W'(1);
                end
            end
            CMD_ALLOC_LINK: begin
                node_we    = 1'b1;
                node_waddr = cur_reg;
                node_wdata = nd_reg;
                if (link_bit) begin
                    node_wdata.child_one = new_reg;
                    node_wdata.flags[1]  = 1'b1;
                end else begin
                    node_wdata.child_zero = new_reg;
                    node_wdata.flags[0]   = 1'b1;
                end
                path_we    = 1'b1;
                path_waddr = PATH_AW'(n_reg);
                path_wdata = new_reg;
                cur_next   = new_reg;
                nd_next    = zero_rec;
                n_next     = KEY_LEN_W'(n_reg + KEY_LEN_W'(1));
            end
            CMD_ADD_SET: begin
                node_we          = 1'b1;
                node_waddr       = cur_reg;
                node_wdata       = nd_reg;
                node_wdata.valid = 1'b1;
                node_wdata.value = val_reg;
            end
            CMD_PRUNE_WR: begin
                node_we    = 1'b1;
                node_waddr = cur_reg;
                node_wdata = nd_reg;
                if (!dp_status.prune_stop) begin
                    if (free_count_reg < COUNT_W'(NODES)) begin
                        free_we         = 1'b1;
                        free_count_next = COUNT_W'(free_count_reg + COUNT_W'(1));
                    end
                    if (i_reg == '0) begin
                        root_present_next = 1'b0;
                        root_next         = '0;
                    end
                end
            end
            CMD_PATH_LOAD: begin
                cur_next = path_dout_reg;
            end
            CMD_PRUNE_MOD: begin
                nd_next                  = node_dout_reg;
                nd_next.flags[prune_bit] = 1'b0;
                i_next                   = KEY_LEN_W'(i_reg - KEY_LEN_W'(1));
            end
            CMD_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_found_next  = res_found_reg;
                    m_value_next  = res_value_reg;
                    m_status_next = res_status_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        node_dout_reg     <= node_mem[cur_reg];
        free_dout_reg     <= free_mem[free_top[NODE_AW-1:0]];
        free_init_reg     <= NODE_AW'(NODES - 1) - free_top[NODE_AW-1:0];
        free_use_init_reg <= free_top < low_mark_reg;
        path_dout_reg     <= path_mem[PATH_AW'(i_reg - KEY_LEN_W'(1))];
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (free_we) begin
            free_mem[free_count_reg[NODE_AW-1:0]] <= cur_reg;
        end
        if (path_we) begin
            path_mem[path_waddr] <= path_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        kl_reg         <= kl_next;
        len_reg        <= len_next;
        val_reg        <= val_next;
        n_reg          <= n_next;
        i_reg          <= i_next;
        cur_reg        <= cur_next;
        new_reg        <= new_next;
        nd_reg         <= nd_next;
        root_reg       <= root_next;
        res_found_reg  <= res_found_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_found_reg    <= m_found_next;
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg   <= KEY_LEN_RESET;
            root_present_reg <= 1'b0;
            free_count_reg   <= COUNT_W'(NODES);
            low_mark_reg     <= COUNT_W'(NODES);
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                key_length_reg <= cfg_wr_data;
            end
            root_present_reg <= root_present_next;
            free_count_reg   <= free_count_next;
            low_mark_reg     <= low_mark_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_result_value = m_value_reg;
    assign m_status       = m_status_reg;

endmodule
`default_nettype wire

// ===== hdl/binary_trie_prefix_table_unit.sv =====
// Operation: a request walks at most 33 trie levels from the root; an add then
//   allocates the missing nodes (a new root if the trie is empty) and stores the value,
//   and a remove clears the value and frees empty nodes, visiting parents up the path.
// Throughput: one request at a time; s_ready rises again in the same cycle that
//   m_valid presents the registered result.
// Reset: synchronous, active low; empties the trie, key_length = 32, no sweep.
`default_nettype none
module binary_trie_prefix_table_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [btpt_pkg::KEY_LEN_W-1:0]     cfg_wr_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [1:0]                         s_op,
    input  wire logic [btpt_pkg::MAX_KEY_BITS-1:0]  s_key,
    input  wire logic [btpt_pkg::KEY_LEN_W-1:0]     s_prefix_len,
    input  wire logic [btpt_pkg::VALUE_BITS-1:0]    s_value,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_found,
    output logic [btpt_pkg::VALUE_BITS-1:0]         m_result_value,
    output logic [1:0]                              m_status
);
    import btpt_pkg::*;

    cmd_t       cmd;
    dp_status_t dp_status;

    btpt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    btpt_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .dp_status      (dp_status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_op           (s_op),
        .s_key          (s_key),
        .s_prefix_len   (s_prefix_len),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_result_value (m_result_value),
        .m_status       (m_status)
    );

endmodule
`default_nettype wire
